FILE: rtl/window_3x3_packetizer_defines.svh
// Assertion macros shared by the window packetizer checker.
`ifndef WINDOW_3X3_PACKETIZER_DEFINES_SVH
`define WINDOW_3X3_PACKETIZER_DEFINES_SVH

// same-cycle implication
`define WIN3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WIN3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/win3_pkg.sv
// Shared constants and types for the 3x3 window packetizer.
package win3_pkg;

    localparam int PIXEL_W       = 8;
    localparam int KERNEL_W      = 36;
    localparam int DIM_W         = 4;
    localparam int POS_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int MIN_DIM       = 3;
    localparam int MAX_WIDTH_DEF = 8;
    localparam int MAX_HEIGHT_DEF = 8;

    localparam logic [KERNEL_W-1:0] KERNEL_RST = '0;
    localparam logic [DIM_W-1:0]    WIDTH_RST  = 4'd6;
    localparam logic [DIM_W-1:0]    HEIGHT_RST = 4'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

endpackage

FILE: rtl/window_3x3_packetizer.sv
// 3x3 sliding-window packetizer: line buffers, window registers, output register.
// Usage:
//   Pixels enter in raster order on pixel / pixel_valid / pixel_stall; a
//   transaction completes when pixel_valid is high and pixel_stall is low.
//   Every pixel at row >= 2 and column >= 2 completes a 3x3 window and
//   yields one output transaction on window_valid / window_stall carrying
//   the kernel word, the nine window pixels and the window's top-left
//   position. Other pixels produce nothing.
//   Configuration (kernel word, width, height) is written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data while the block is idle;
//   cfg_ready is always high. Out-of-range dimensions are clamped.
//   window_valid rises in the cycle after a window-completing pixel is accepted.
//   Throughput: one pixel per cycle while pixel_stall is low; the line buffers are
//   one RAM whose registered read is prefetched at the next column, so no bubble
//   is needed. Reset clears the row/column counters and the output valid and sets
//   the configuration to its defaults; line buffer contents stay undefined until
//   written. When the receiver stalls with a window pending, only pixels that
//   would produce another window are stalled; other pixels keep flowing.
module window_3x3_packetizer #(
    parameter int MAX_WIDTH  = win3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = win3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [win3_pkg::PIXEL_W-1:0]   pixel,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [win3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [win3_pkg::KERNEL_W-1:0]  cfg_data,
    output logic                           window_valid,
    input  logic                           window_stall,
    output logic [win3_pkg::KERNEL_W-1:0]  kernel_out,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_top_left,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_top_mid,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_top_right,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_mid_left,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_center,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_mid_right,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_bot_left,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_bot_mid,
    output logic [win3_pkg::PIXEL_W-1:0]   pix_bot_right,
    output logic [win3_pkg::POS_W-1:0]     window_row,
    output logic [win3_pkg::POS_W-1:0]     window_col
);

    localparam int PW     = win3_pkg::PIXEL_W;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = (CW + 1 > win3_pkg::DIM_W) ? CW + 1 : win3_pkg::DIM_W;
    localparam int HCMP_W = (RW + 1 > win3_pkg::DIM_W) ? RW + 1 : win3_pkg::DIM_W;
    localparam int CPOS_W = (CW > win3_pkg::POS_W) ? CW : win3_pkg::POS_W;
    localparam int RPOS_W = (RW > win3_pkg::POS_W) ? RW : win3_pkg::POS_W;

    // configuration
    logic [win3_pkg::KERNEL_W-1:0] kernel_reg;
    logic [win3_pkg::DIM_W-1:0]    width_reg;
    logic [win3_pkg::DIM_W-1:0]    height_reg;

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // window columns 0 and 1 on output; column 2 comes straight from the line buffer and pixel
    logic [PW-1:0] top_mid_reg, top_right_reg;
    logic [PW-1:0] mid_mid_reg, mid_right_reg;
    logic [PW-1:0] bot_mid_reg, bot_right_reg;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [win3_pkg::KERNEL_W-1:0] kernel_out_reg;
    logic [PW-1:0]                 tl_reg, tm_reg, tr_reg;
    logic [PW-1:0]                 ml_reg, mc_reg, mr_reg;
    logic [PW-1:0]                 bl_reg, bm_reg, br_reg;
    logic [win3_pkg::POS_W-1:0]    wrow_reg, wcol_reg;

    logic [WCMP_W-1:0] w_raw, w_eff;
    logic [HCMP_W-1:0] h_raw, h_eff;
    logic              col_wrap, row_wrap;
    logic              produce, accept, load;
    logic [CW-1:0]     col_adv;
    logic [RW-1:0]     row_adv;

    logic [2*PW-1:0] lb_rdata, lb_wdata;
    logic [CW-1:0]   lb_raddr;
    logic [PW-1:0]   lb_upper, lb_lower;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= win3_pkg::KERNEL_RST;
            width_reg  <= win3_pkg::WIDTH_RST;
            height_reg <= win3_pkg::HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                win3_pkg::REG_KERNEL: kernel_reg <= cfg_data;
                win3_pkg::REG_WIDTH:  width_reg  <= cfg_data[win3_pkg::DIM_W-1:0];
                win3_pkg::REG_HEIGHT: height_reg <= cfg_data[win3_pkg::DIM_W-1:0];
                default:              ;
            endcase
        end
    end

    // clamp dimensions to [3, MAX]
    always_comb
    begin
        w_raw = WCMP_W'(width_reg);
        h_raw = HCMP_W'(height_reg);
        if (w_raw < WCMP_W'(win3_pkg::MIN_DIM))
            w_eff = WCMP_W'(win3_pkg::MIN_DIM);
        else if (w_raw > WCMP_W'(MAX_WIDTH))
            w_eff = WCMP_W'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < HCMP_W'(win3_pkg::MIN_DIM))
            h_eff = HCMP_W'(win3_pkg::MIN_DIM);
        else if (h_raw > HCMP_W'(MAX_HEIGHT))
            h_eff = HCMP_W'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    assign col_wrap = (WCMP_W'(col_reg) + WCMP_W'(1)) >= w_eff;
    assign row_wrap = (HCMP_W'(row_reg) + HCMP_W'(1)) >= h_eff;
    assign col_adv  = col_wrap ? '0 : col_reg + CW'(1);
    assign row_adv  = row_wrap ? '0 : row_reg + RW'(1);

    assign produce     = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign pixel_stall = out_valid_reg && window_stall && produce;
    assign accept      = pixel_valid && !pixel_stall;
    assign load        = accept && produce;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = col_adv;
            if (col_wrap)
            begin
                row_next = row_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line buffers: upper byte is row r-2, lower byte is row r-1
    assign lb_raddr = col_next;
    assign lb_upper = lb_rdata[2*PW-1:PW];
    assign lb_lower = lb_rdata[PW-1:0];
    assign lb_wdata = {lb_lower, pixel};

    win3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (lb_wdata),
        .raddr (lb_raddr),
        .rdata (lb_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_mid_reg   <= top_right_reg;
            top_right_reg <= lb_upper;
            mid_mid_reg   <= mid_right_reg;
            mid_right_reg <= lb_lower;
            bot_mid_reg   <= bot_right_reg;
            bot_right_reg <= pixel;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !window_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kernel_out_reg <= kernel_reg;
            tl_reg         <= top_mid_reg;
            tm_reg         <= top_right_reg;
            tr_reg         <= lb_upper;
            ml_reg         <= mid_mid_reg;
            mc_reg         <= mid_right_reg;
            mr_reg         <= lb_lower;
            bl_reg         <= bot_mid_reg;
            bm_reg         <= bot_right_reg;
            br_reg         <= pixel;
            wrow_reg       <= win3_pkg::POS_W'(RPOS_W'(row_reg) - RPOS_W'(2));
            wcol_reg       <= win3_pkg::POS_W'(CPOS_W'(col_reg) - CPOS_W'(2));
        end
    end

    assign window_valid  = out_valid_reg;
    assign kernel_out    = kernel_out_reg;
    assign pix_top_left  = tl_reg;
    assign pix_top_mid   = tm_reg;
    assign pix_top_right = tr_reg;
    assign pix_mid_left  = ml_reg;
    assign pix_center    = mc_reg;
    assign pix_mid_right = mr_reg;
    assign pix_bot_left  = bl_reg;
    assign pix_bot_mid   = bm_reg;
    assign pix_bot_right = br_reg;
    assign window_row    = wrow_reg;
    assign window_col    = wcol_reg;

endmodule

FILE: rtl/win3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module win3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/win3_checker.sv
// Port-level checker for the 3x3 window packetizer, bound to the top level.
`include "window_3x3_packetizer_defines.svh"

module win3_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pixel_valid,
    input logic                           pixel_stall,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           window_valid,
    input logic                           window_stall,
    input logic [win3_pkg::KERNEL_W-1:0]  kernel_out,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_top_left,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_top_mid,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_top_right,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_mid_left,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_center,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_mid_right,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_bot_left,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_bot_mid,
    input logic [win3_pkg::PIXEL_W-1:0]   pix_bot_right,
    input logic [win3_pkg::POS_W-1:0]     window_row,
    input logic [win3_pkg::POS_W-1:0]     window_col
);

    logic [win3_pkg::KERNEL_W+9*win3_pkg::PIXEL_W+2*win3_pkg::POS_W-1:0] payload;

    assign payload = {kernel_out, pix_top_left, pix_top_mid, pix_top_right,
                      pix_mid_left, pix_center, pix_mid_right,
                      pix_bot_left, pix_bot_mid, pix_bot_right,
                      window_row, window_col};

    // input side only backs up behind a stalled pending window
    `WIN3_ASSERT_NOW(a_stall_cause, clk, rst_n, pixel_stall,
        window_valid && window_stall, "pixel_stall without a stalled window")

    // a new window needs a pixel transaction on the previous edge
    `WIN3_ASSERT_NOW(a_window_source, clk, rst_n, $rose(window_valid),
        $past(pixel_valid && !pixel_stall), "window without a pixel transaction")

    `WIN3_ASSERT_NEXT(a_window_hold, clk, rst_n, window_valid && window_stall,
        window_valid && $stable(payload), "stalled window changed")

    `WIN3_ASSERT_NOW(a_window_drop, clk, rst_n, $fell(window_valid),
        $past(!window_stall), "window dropped without a transaction")

    // configuration channel is never back-pressured
    `WIN3_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid,
        cfg_ready, "configuration write refused")

endmodule

bind window_3x3_packetizer win3_checker u_win3_checker (.*);
